/* rtl/core/lcfp_pkg.sv */
`timescale 1ns / 1ps

package lcfp_pkg;

    // Framing bytes.
    localparam logic [7:0] FRAME_START = 8'h02;
    localparam logic [7:0] FRAME_END   = 8'h03;

    // Input operation codes.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // Parser phase codes.
    typedef logic [2:0] t_phase;
    localparam t_phase PH_START   = 3'd0;
    localparam t_phase PH_LENGTH  = 3'd1;
    localparam t_phase PH_PAYLOAD = 3'd2;
    localparam t_phase PH_CHECK   = 3'd3;
    localparam t_phase PH_END     = 3'd4;
    localparam t_phase PH_DONE    = 3'd5;
    localparam t_phase PH_ERROR   = 3'd6;

    // Frame status codes.
    typedef logic [1:0] t_status;
    localparam t_status STAT_RUN   = 2'd0;
    localparam t_status STAT_DONE  = 2'd1;
    localparam t_status STAT_ERROR = 2'd2;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        t_status    frame_status;
        logic [7:0] frame_length;
        t_phase     parse_phase;
    } t_out_item;

endpackage

/* rtl/core/lcfp_stream_if.sv */
`timescale 1ns / 1ps

// Channel carrying received bytes and restart requests.
interface lcfp_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;

    modport source (output valid, output operation, output rx_byte, input ready);
    modport sink   (input valid, input operation, input rx_byte, output ready);
endinterface

// Channel carrying one parse result per accepted input transaction.
interface lcfp_out_if;
    logic       valid;
    logic       ready;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [1:0] frame_status;
    logic [7:0] frame_length;
    logic [2:0] parse_phase;

    modport source (
        output valid, output payload_valid, output payload_byte, output payload_index,
        output frame_status, output frame_length, output parse_phase, input ready
    );
    modport sink (
        input valid, input payload_valid, input payload_byte, input payload_index,
        input frame_status, input frame_length, input parse_phase, output ready
    );
endinterface

/* rtl/core/lcfp_parser.sv */
`timescale 1ns / 1ps

// Frame state and its next-state logic. The result for an item is formed
// in the same cycle the item is taken.
module lcfp_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  lcfp_pkg::t_in_item  i_item,
    output lcfp_pkg::t_out_item o_result,
    output lcfp_pkg::t_phase    o_phase
);
    import lcfp_pkg::*;

    t_phase     r_phase,  n_phase;
    logic [7:0] r_length, n_length;
    logic [7:0] r_count,  n_count;
    logic [7:0] r_sum,    n_sum;
    logic       pay_valid;
    logic [7:0] pay_byte;
    logic [7:0] pay_index;
    t_status    status;

    always_comb begin
        n_phase   = r_phase;
        n_length  = r_length;
        n_count   = r_count;
        n_sum     = r_sum;
        pay_valid = 1'b0;
        pay_byte  = 8'd0;
        pay_index = 8'd0;

        if (i_item.operation == OP_RESTART) begin
            n_phase = PH_START;
            n_count = 8'd0;
            n_sum   = 8'd0;
        end else begin
            unique case (r_phase) inside
                PH_START: begin
                    if (i_item.rx_byte == FRAME_START) begin
                        n_sum   = 8'd0;
                        n_count = 8'd0;
                        n_phase = PH_LENGTH;
                    end else begin
                        n_phase = PH_ERROR;
                    end
                end
                PH_LENGTH: begin
                    n_length = i_item.rx_byte;
                    n_sum    = i_item.rx_byte;
                    n_count  = 8'd0;
                    n_phase  = (i_item.rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    pay_valid = 1'b1;
                    pay_byte  = i_item.rx_byte;
                    pay_index = r_count;
                    n_sum     = r_sum + i_item.rx_byte;
                    n_count   = r_count + 8'd1;
                    if (n_count >= r_length) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    n_phase = (i_item.rx_byte == r_sum) ? PH_END : PH_ERROR;
                end
                PH_END: begin
                    n_phase = (i_item.rx_byte == FRAME_END) ? PH_DONE : PH_ERROR;
                end
                PH_DONE, PH_ERROR: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = PH_ERROR;
                end
            endcase
        end
    end

    always_comb begin
        if (n_phase == PH_DONE) begin
            status = STAT_DONE;
        end else if (n_phase == PH_ERROR) begin
            status = STAT_ERROR;
        end else begin
            status = STAT_RUN;
        end
    end

    assign o_result = '{
        payload_valid: pay_valid,
        payload_byte:  pay_byte,
        payload_index: pay_index,
        frame_status:  status,
        frame_length:  n_length,
        parse_phase:   n_phase
    };
    assign o_phase = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_length <= 8'd0;
            r_count  <= 8'd0;
            r_sum    <= 8'd0;
        end else if (i_take) begin
            r_phase  <= n_phase;
            r_length <= n_length;
            r_count  <= n_count;
            r_sum    <= n_sum;
        end
    end

endmodule

/* rtl/core/lcfp_out_stage.sv */
`timescale 1ns / 1ps

// Result register. It can load a new result whenever it is empty or its
// current result leaves in the same cycle.
module lcfp_out_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  lcfp_pkg::t_out_item i_result,
    input  logic                i_ready,
    output logic                o_can_load,
    output logic                o_valid,
    output lcfp_pkg::t_out_item o_result
);
    import lcfp_pkg::*;

    logic      r_valid;
    t_out_item r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

/* rtl/core/length_checksum_frame_parser_core.sv */
`timescale 1ns / 1ps

// Channel   Modport  Payload
// i_in      sink     operation (1), rx_byte (8)
// o_out     source   payload_valid (1), payload_byte (8), payload_index (8),
//                    frame_status (2), frame_length (8), parse_phase (3)
//
// One input transaction is taken per cycle while the output is not stalled;
// its result appears in the output register on the next cycle, so throughput
// is one transaction per clock. The rate is set by the single frame-state update,
// a compare and an 8-bit add. A synchronous active-low reset returns the
// parser to waiting for the start byte with an empty output register. When
// the output is stalled with a result held, the input is not ready.
module length_checksum_frame_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcfp_in_if.sink     i_in,
    lcfp_out_if.source  o_out
);
    import lcfp_pkg::*;

    t_in_item  in_item;
    t_out_item step_result;
    t_out_item held_result;
    t_phase    cur_phase;
    logic      take;
    logic      can_load;
    logic      out_valid;

    // Each transaction is processed in full during the cycle it is accepted.
    assign in_item = '{operation: i_in.operation, rx_byte: i_in.rx_byte};
    assign i_in.ready = can_load;
    assign take = i_in.valid && can_load;

    lcfp_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (take),
        .i_item   (in_item),
        .o_result (step_result),
        .o_phase  (cur_phase)
    );

    lcfp_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take),
        .i_result   (step_result),
        .i_ready    (o_out.ready),
        .o_can_load (can_load),
        .o_valid    (out_valid),
        .o_result   (held_result)
    );

    assign o_out.valid         = out_valid;
    assign o_out.payload_valid = held_result.payload_valid;
    assign o_out.payload_byte  = held_result.payload_byte;
    assign o_out.payload_index = held_result.payload_index;
    assign o_out.frame_status  = held_result.frame_status;
    assign o_out.frame_length  = held_result.frame_length;
    assign o_out.parse_phase   = held_result.parse_phase;

`ifndef SYNTHESIS
    // An accepted transaction always leaves a result in the output register.
    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> o_out.valid)
        else $error("accepted transaction produced no result");

    // A restart puts the parser back to waiting for the start byte.
    a_restart_to_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && (i_in.operation == OP_RESTART) |=> cur_phase == PH_START)
        else $error("restart did not return the parser to start");

    // A payload byte leaves the parser in the payload or checksum phase with a running status.
    a_payload_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.payload_valid |->
            (o_out.parse_phase == PH_PAYLOAD || o_out.parse_phase == PH_CHECK) &&
            o_out.frame_status == STAT_RUN)
        else $error("payload result with inconsistent phase or status");

    // A held, stalled result blocks the input side.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |-> !i_in.ready)
        else $error("input ready while the result register is stalled");
`endif

endmodule
